// ===== sv/kpv_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// kpv_pkg
// Types, constants and helpers shared by the position/velocity filter.
// ---------------------------------------------------------------------------
package kpv_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DT_BITS   = 16;
	localparam int WIDE_W    = 64;
	localparam int MAG_W     = 34;              // multiplier operand magnitude
	localparam int HALF_W    = MAG_W / 2;
	localparam int PROD_W    = 2 * MAG_W;
	localparam int DEN_W     = 33;              // P00 + R
	localparam int NMAG_W    = 33;              // divider numerator magnitude
	localparam int NUM_W     = NMAG_W + FRAC_BITS;
	localparam int CIDX_W    = 3;

	typedef logic signed [WIDE_W-1:0] wide_t;

	localparam wide_t S32_MAX = 64'sd2147483647;
	localparam wide_t S32_MIN = -64'sd2147483648;
	localparam wide_t U32_MAX = 64'sd4294967295;
	localparam wide_t ONE_Q   = wide_t'(64'sd1 <<< FRAC_BITS);

	localparam logic [CIDX_W-1:0] REG_TIME_STEP  = 3'd0;
	localparam logic [CIDX_W-1:0] REG_MEAS_NOISE = 3'd1;
	localparam logic [CIDX_W-1:0] REG_PROC_NOISE = 3'd2;
	localparam logic [CIDX_W-1:0] REG_INIT_POS   = 3'd3;
	localparam logic [CIDX_W-1:0] REG_INIT_VEL   = 3'd4;
	localparam logic [CIDX_W-1:0] REG_INIT_COV   = 3'd5;

	localparam logic [15:0] TIME_STEP_RST  = 16'd6554;
	localparam logic [31:0] MEAS_NOISE_RST = 32'd262144;
	localparam logic [31:0] PROC_NOISE_RST = 32'd655;
	localparam logic [31:0] INIT_COV_RST   = 32'd6553600;

	typedef struct packed {
		logic signed [31:0] acceleration;
		logic signed [31:0] measured_position;
		logic               restart;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] position_estimate;
		logic signed [31:0] velocity_estimate;
		logic        [31:0] position_variance;
		logic               saturated;
	} out_item_t;

	typedef enum logic [1:0] {SH_DT, SH_DT1, SH_FRAC} shift_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_M_ADT, OP_M_VDT, OP_M_ADT2, OP_M_DTVP, OP_M_DTVV, OP_PRED,
		OP_M_FP01, OP_P00, OP_D_K0, OP_D_K1, OP_M_K0Y, OP_M_K1Y, OP_M_P00,
		OP_M_P01, OP_M_K1P00, OP_M_K1P01, OP_UPD
	} op_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_M_ADT, ST_M_VDT, ST_M_ADT2, ST_M_DTVP, ST_M_DTVV, ST_PRED,
		ST_M_FP01, ST_P00, ST_CHK, ST_D_K0, ST_D_K1, ST_M_K0Y, ST_M_K1Y,
		ST_M_P00, ST_M_P01, ST_M_K1P00, ST_M_K1P01, ST_UPD, ST_OUT
	} state_t;

	typedef struct packed {
		op_t  op;
		logic start;
		logic capture;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
		logic s_zero;
	} status_t;

	typedef struct packed {
		logic        clip;
		logic [31:0] val;
	} sat_t;

	function automatic wide_t sx32(logic [31:0] v);
		return wide_t'($signed(v));
	endfunction

	function automatic wide_t zx32(logic [31:0] v);
		return $signed({32'b0, v});
	endfunction

	function automatic sat_t sat_s(wide_t v);
		sat_t r;
		r.clip = 1'b0;
		r.val  = v[31:0];
		if (v > S32_MAX) begin
			r.clip = 1'b1;
			r.val  = S32_MAX[31:0];
		end else if (v < S32_MIN) begin
			r.clip = 1'b1;
			r.val  = S32_MIN[31:0];
		end
		return r;
	endfunction

	function automatic sat_t sat_u(wide_t v);
		sat_t r;
		r.clip = 1'b0;
		r.val  = v[31:0];
		if (v > U32_MAX) begin
			r.clip = 1'b1;
			r.val  = U32_MAX[31:0];
		end else if (v < 0) begin
			r.clip = 1'b1;
			r.val  = 32'd0;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== sv/kalman_position_velocity_filter_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// kalman_position_velocity_filter_core
// Two-state position/velocity Kalman filter, Q16.16, predict then correct.
// ---------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_ready   in_data  (acceleration, position, restart)
//  out      out_valid / out_ready out_data (position, velocity, P00, sat)
//  cfg      cfg_we                cfg_index, cfg_data
//
// Per request: twelve multiplies on the shared two-pass multiplier and two
// divides (one quotient bit a cycle).
// With P00 + R equal to zero the correction is skipped.
// Reset restores config registers, filter state and control state at once; the
// temporaries and output data are not reset. A finished result waits in the output
// register; the next request is taken meanwhile and stalls only at its own output step.
// ---------------------------------------------------------------------------
module kalman_position_velocity_filter_core import kpv_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire in_item_t          in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output out_item_t              out_data,
	input  wire logic              cfg_we,
	input  wire logic [CIDX_W-1:0] cfg_index,
	input  wire logic [31:0]       cfg_data
);

	cmd_t    cmd;
	status_t status;

	kpv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	kpv_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (in_data),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule
`default_nettype wire

// ===== sv/kpv_mul.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// kpv_mul
// Sign-magnitude multiplier, two partial products (b by each half of a), then a
// round-to-nearest (ties away from zero) right shift.
// ---------------------------------------------------------------------------
module kpv_mul import kpv_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  start,
	input  wire wide_t a,
	input  wire wide_t b,
	input  wire shift_t sh,
	output logic       done,
	output wide_t      res
);

	logic [MAG_W-1:0]  ma_q, mb_q;
	logic              neg_q;
	shift_t            sh_q;
	logic [1:0]        cnt_q;
	logic [PROD_W-1:0] acc_q;
	logic [PROD_W-1:0] rnd;
	logic [PROD_W-1:0] mag_res;
	wide_t             abs_a, abs_b;

	assign abs_a = a[WIDE_W-1] ? -a : a;
	assign abs_b = b[WIDE_W-1] ? -b : b;

	always_comb begin
		rnd = '0;
		case (sh_q)
			SH_DT:   rnd = (acc_q + (PROD_W'(1) << (DT_BITS - 1))) >> DT_BITS;
			SH_DT1:  rnd = (acc_q + (PROD_W'(1) << DT_BITS)) >> (DT_BITS + 1);
			default: rnd = (acc_q + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		endcase
		mag_res = rnd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				cnt_q <= 2'd1;
			end else if (cnt_q == 2'd3) begin
				cnt_q <= 2'd0;
				done  <= 1'b1;
			end else if (cnt_q != 2'd0) begin
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= abs_a[MAG_W-1:0];
			mb_q  <= abs_b[MAG_W-1:0];
			neg_q <= a[WIDE_W-1] ^ b[WIDE_W-1];
			sh_q  <= sh;
		end else begin
			case (cnt_q)
				2'd1: acc_q <= PROD_W'(mb_q * ma_q[HALF_W-1:0]);
				2'd2: acc_q <= acc_q + (PROD_W'(mb_q * ma_q[MAG_W-1:HALF_W]) << HALF_W);
				2'd3: res   <= neg_q ? -wide_t'(mag_res) : wide_t'(mag_res);
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/kpv_div.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// kpv_div
// Restoring divider, one quotient bit a cycle: round(num * 2^F / den).
// ---------------------------------------------------------------------------
module kpv_div import kpv_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire wide_t            num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output wide_t                 res
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] n_q;
	logic [DEN_W-1:0] den_q, rem_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   rem_sh;
	logic             qbit;
	wide_t            abs_num;

	assign abs_num = num[WIDE_W-1] ? -num : num;
	assign rem_sh  = {rem_q, n_q[NUM_W-1]};
	assign qbit    = rem_sh >= {1'b0, den_q};

	// quotient has fully replaced the dividend by the cycle done is high
	assign res = neg_q ? -wide_t'(n_q) : wide_t'(n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= (NUM_W'(abs_num[NMAG_W-1:0]) << FRAC_BITS) + NUM_W'(den >> 1);
			den_q <= den;
			rem_q <= '0;
			neg_q <= num[WIDE_W-1];
		end else if (busy_q) begin
			rem_q <= qbit ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
			n_q   <= {n_q[NUM_W-2:0], qbit};
		end
	end

endmodule
`default_nettype wire

// ===== sv/kpv_datapath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// kpv_datapath
// Config registers, filter state, temporaries, shared multiplier and divider.
// ---------------------------------------------------------------------------
module kpv_datapath import kpv_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	output status_t                status,
	input  wire in_item_t          in_data,
	output out_item_t              out_data,
	input  wire logic              cfg_we,
	input  wire logic [CIDX_W-1:0] cfg_index,
	input  wire logic [31:0]       cfg_data
);

	logic [15:0] time_step_q;
	logic [31:0] meas_noise_q, proc_noise_q, init_pos_q, init_vel_q, init_cov_q;

	logic [31:0] est_pos_q, est_vel_q, cov_pp_q, cov_pv_q, cov_vp_q, cov_vv_q;
	logic [31:0] acc_q, z_q;
	logic        clip_q;
	wide_t       adt_q, t1_q, t2_q, t3_q, t4_q, t5_q, t6_q, fp00_q, fp01_q, y_q, k0_q;
	logic [31:0] k1_q;
	logic [DEN_W-1:0] s_q;

	wide_t  mul_a, mul_b, mul_res, div_num, div_res, dt_w, onek0, fp01_c;
	shift_t mul_sh;
	logic   mul_start, div_start, mul_done, div_done;
	sat_t   pr_pos, pr_vel, pr_pv, pr_vp, pr_vv, pp00, sk1;
	sat_t   up_pos, up_vel, up_pp, up_pv, up_vp, up_vv;

	assign dt_w  = zx32({16'b0, time_step_q});
	assign onek0 = ONE_Q - k0_q;

	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		mul_sh    = SH_FRAC;
		mul_start = cmd.start;
		div_start = 1'b0;
		div_num   = zx32(cov_pp_q);
		case (cmd.op)
			OP_M_ADT:   begin mul_a = sx32(acc_q);     mul_b = dt_w; mul_sh = SH_DT;  end
			OP_M_VDT:   begin mul_a = sx32(est_vel_q); mul_b = dt_w; mul_sh = SH_DT;  end
			OP_M_ADT2:  begin mul_a = adt_q;           mul_b = dt_w; mul_sh = SH_DT1; end
			OP_M_DTVP:  begin mul_a = dt_w; mul_b = sx32(cov_vp_q);  mul_sh = SH_DT;  end
			OP_M_DTVV:  begin mul_a = dt_w; mul_b = zx32(cov_vv_q);  mul_sh = SH_DT;  end
			OP_M_FP01:  begin mul_a = fp01_q;          mul_b = dt_w; mul_sh = SH_DT;  end
			OP_M_K0Y:   begin mul_a = k0_q;            mul_b = y_q;                   end
			OP_M_K1Y:   begin mul_a = sx32(k1_q);      mul_b = y_q;                   end
			OP_M_P00:   begin mul_a = onek0;           mul_b = zx32(cov_pp_q);        end
			OP_M_P01:   begin mul_a = onek0;           mul_b = sx32(cov_pv_q);        end
			OP_M_K1P00: begin mul_a = sx32(k1_q);      mul_b = zx32(cov_pp_q);        end
			OP_M_K1P01: begin mul_a = sx32(k1_q);      mul_b = sx32(cov_pv_q);        end
			OP_D_K0:    begin mul_start = 1'b0; div_start = cmd.start;                end
			OP_D_K1:    begin
				mul_start = 1'b0;
				div_start = cmd.start;
				div_num   = sx32(cov_vp_q);
			end
			default:    mul_start = 1'b0;
		endcase
	end

	kpv_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.sh     (mul_sh),
		.done   (mul_done),
		.res    (mul_res)
	);

	kpv_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (s_q),
		.done   (div_done),
		.res    (div_res)
	);

	assign status.mul_done = mul_done;
	assign status.div_done = div_done;
	assign status.s_zero   = (s_q == '0);

	always_comb begin
		fp01_c = sx32(cov_pv_q) + t4_q;
		pr_pos = sat_s(sx32(est_pos_q) + t1_q + t2_q);
		pr_vel = sat_s(sx32(est_vel_q) + adt_q);
		pr_pv  = sat_s(fp01_c);
		pr_vp  = sat_s(sx32(cov_vp_q) + t4_q);
		pr_vv  = sat_u(zx32(cov_vv_q) + zx32(proc_noise_q));
		pp00   = sat_u(fp00_q + t5_q + zx32(proc_noise_q));
		sk1    = sat_s(div_res);
		up_pos = sat_s(sx32(est_pos_q) + t1_q);
		up_vel = sat_s(sx32(est_vel_q) + t2_q);
		up_pp  = sat_u(t3_q);
		up_pv  = sat_s(t4_q);
		up_vp  = sat_s(sx32(cov_vp_q) - t5_q);
		up_vv  = sat_u(zx32(cov_vv_q) - t6_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q  <= TIME_STEP_RST;
			meas_noise_q <= MEAS_NOISE_RST;
			proc_noise_q <= PROC_NOISE_RST;
			init_pos_q   <= '0;
			init_vel_q   <= '0;
			init_cov_q   <= INIT_COV_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TIME_STEP:  time_step_q  <= cfg_data[15:0];
				REG_MEAS_NOISE: meas_noise_q <= cfg_data;
				REG_PROC_NOISE: proc_noise_q <= cfg_data;
				REG_INIT_POS:   init_pos_q   <= cfg_data;
				REG_INIT_VEL:   init_vel_q   <= cfg_data;
				REG_INIT_COV:   init_cov_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_pos_q <= '0;
			est_vel_q <= '0;
			cov_pp_q  <= INIT_COV_RST;
			cov_pv_q  <= '0;
			cov_vp_q  <= '0;
			cov_vv_q  <= INIT_COV_RST;
		end else begin
			if (cmd.capture && in_data.restart) begin
				est_pos_q <= init_pos_q;
				est_vel_q <= init_vel_q;
				cov_pp_q  <= init_cov_q;
				cov_vv_q  <= init_cov_q;
				cov_pv_q  <= '0;
				cov_vp_q  <= '0;
			end
			case (cmd.op)
				OP_PRED: begin
					est_pos_q <= pr_pos.val;
					est_vel_q <= pr_vel.val;
					cov_pv_q  <= pr_pv.val;
					cov_vp_q  <= pr_vp.val;
					cov_vv_q  <= pr_vv.val;
				end
				OP_P00: cov_pp_q <= pp00.val;
				OP_UPD: begin
					est_pos_q <= up_pos.val;
					est_vel_q <= up_vel.val;
					cov_pp_q  <= up_pp.val;
					cov_pv_q  <= up_pv.val;
					cov_vp_q  <= up_vp.val;
					cov_vv_q  <= up_vv.val;
				end
				default: ;
			endcase
		end
	end

	// temporaries, the sticky clip flag and the output register
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			acc_q  <= in_data.acceleration;
			z_q    <= in_data.measured_position;
			clip_q <= 1'b0;
		end
		case (cmd.op)
			OP_PRED: begin
				fp00_q <= zx32(cov_pp_q) + t3_q;
				fp01_q <= fp01_c;
				clip_q <= clip_q | pr_pos.clip | pr_vel.clip | pr_pv.clip | pr_vp.clip
					| pr_vv.clip;
			end
			OP_P00: begin
				s_q    <= DEN_W'(zx32(pp00.val) + zx32(meas_noise_q));
				y_q    <= sx32(z_q) - sx32(est_pos_q);
				clip_q <= clip_q | pp00.clip;
			end
			OP_UPD: clip_q <= clip_q | up_pos.clip | up_vel.clip | up_pp.clip | up_pv.clip
				| up_vp.clip | up_vv.clip;
			default: ;
		endcase
		if (mul_done) begin
			case (cmd.op)
				OP_M_ADT:   adt_q <= mul_res;
				OP_M_VDT,   OP_M_K0Y:   t1_q <= mul_res;
				OP_M_ADT2,  OP_M_K1Y:   t2_q <= mul_res;
				OP_M_DTVP,  OP_M_P00:   t3_q <= mul_res;
				OP_M_DTVV,  OP_M_P01:   t4_q <= mul_res;
				OP_M_FP01,  OP_M_K1P00: t5_q <= mul_res;
				OP_M_K1P01: t6_q <= mul_res;
				default: ;
			endcase
		end
		if (div_done) begin
			case (cmd.op)
				OP_D_K0: k0_q <= div_res;
				OP_D_K1: begin
					k1_q   <= sk1.val;
					clip_q <= clip_q | sk1.clip;
				end
				default: ;
			endcase
		end
		if (cmd.out_load) begin
			out_data.position_estimate <= est_pos_q;
			out_data.velocity_estimate <= est_vel_q;
			out_data.position_variance <= cov_pp_q;
			out_data.saturated         <= clip_q;
		end
	end

endmodule
`default_nettype wire

// ===== sv/kpv_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// kpv_ctrl
// Sequencer: walks predict and update steps, drives the datapath.
// ---------------------------------------------------------------------------
module kpv_ctrl import kpv_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	output cmd_t         cmd,
	input  wire status_t status
);

	state_t state_q, state_d;
	logic   go_q, go_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			go_q      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			go_q    <= go_d;
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		go_d         = 1'b0;
		in_ready     = 1'b0;
		cmd.op       = OP_NONE;
		cmd.start    = go_q;
		cmd.capture  = 1'b0;
		cmd.out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_M_ADT;
					go_d        = 1'b1;
				end
			end
			ST_M_ADT: begin
				cmd.op = OP_M_ADT;
				if (status.mul_done) begin state_d = ST_M_VDT; go_d = 1'b1; end
			end
			ST_M_VDT: begin
				cmd.op = OP_M_VDT;
				if (status.mul_done) begin state_d = ST_M_ADT2; go_d = 1'b1; end
			end
			ST_M_ADT2: begin
				cmd.op = OP_M_ADT2;
				if (status.mul_done) begin state_d = ST_M_DTVP; go_d = 1'b1; end
			end
			ST_M_DTVP: begin
				cmd.op = OP_M_DTVP;
				if (status.mul_done) begin state_d = ST_M_DTVV; go_d = 1'b1; end
			end
			ST_M_DTVV: begin
				cmd.op = OP_M_DTVV;
				if (status.mul_done) state_d = ST_PRED;
			end
			ST_PRED: begin
				cmd.op  = OP_PRED;
				state_d = ST_M_FP01;
				go_d    = 1'b1;
			end
			ST_M_FP01: begin
				cmd.op = OP_M_FP01;
				if (status.mul_done) state_d = ST_P00;
			end
			ST_P00: begin
				cmd.op  = OP_P00;
				state_d = ST_CHK;
			end
			ST_CHK: begin
				// zero innovation variance: skip the correction
				if (status.s_zero) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_D_K0;
					go_d    = 1'b1;
				end
			end
			ST_D_K0: begin
				cmd.op = OP_D_K0;
				if (status.div_done) begin state_d = ST_D_K1; go_d = 1'b1; end
			end
			ST_D_K1: begin
				cmd.op = OP_D_K1;
				if (status.div_done) begin state_d = ST_M_K0Y; go_d = 1'b1; end
			end
			ST_M_K0Y: begin
				cmd.op = OP_M_K0Y;
				if (status.mul_done) begin state_d = ST_M_K1Y; go_d = 1'b1; end
			end
			ST_M_K1Y: begin
				cmd.op = OP_M_K1Y;
				if (status.mul_done) begin state_d = ST_M_P00; go_d = 1'b1; end
			end
			ST_M_P00: begin
				cmd.op = OP_M_P00;
				if (status.mul_done) begin state_d = ST_M_P01; go_d = 1'b1; end
			end
			ST_M_P01: begin
				cmd.op = OP_M_P01;
				if (status.mul_done) begin state_d = ST_M_K1P00; go_d = 1'b1; end
			end
			ST_M_K1P00: begin
				cmd.op = OP_M_K1P00;
				if (status.mul_done) begin state_d = ST_M_K1P01; go_d = 1'b1; end
			end
			ST_M_K1P01: begin
				cmd.op = OP_M_K1P01;
				if (status.mul_done) state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.op  = OP_UPD;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire
